// ===== hdl/frame_allocator_lru_evict_core_assert.svh =====
// Assertion macros used by the frame allocator datapath.
`ifndef FRAME_ALLOCATOR_LRU_EVICT_CORE_ASSERT_SVH
`define FRAME_ALLOCATOR_LRU_EVICT_CORE_ASSERT_SVH
// Check that cons holds in every cycle in which ante holds.
`define FALE_ASSERT_IMPLIES(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Check that cond holds in every cycle out of reset.
`define FALE_ASSERT_HOLDS(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);
`endif

// ===== hdl/fale_pkg.sv =====
// Types and constants of the frame allocator.
package fale_pkg;

   localparam int CMD_W      = 2;
   localparam int PID_W      = 4;
   localparam int KB_W       = 10;
   localparam int TIME_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int MAP_W      = 64;
   localparam int COUNT_W    = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TOUCH = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ALLOC_MODE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RESIDENT = 1'd1;

   localparam logic MODE_WHOLE   = 1'b0;
   localparam logic MODE_PARTIAL = 1'b1;

   localparam logic [COUNT_W-1:0] MIN_RESIDENT_RST = 7'd4;

   typedef enum logic [1:0] {
      SCAN_VICTIM,
      SCAN_EVICT,
      SCAN_GRANT
   } scan_kind_type;

   typedef struct packed {
      logic          load_req;
      logic          touch_we;
      logic          div_start;
      logic          scan_start;
      scan_kind_type scan_kind;
      logic          use_self;
      logic          limit_all;
      logic          rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             mode;
      logic             div_done;
      logic             scan_done;
      logic             free_lt_pages;
      logic             part_more;
      logic             found;
      logic             want_pos;
      logic             evict_none;
      logic             rsp_free;
   } ctrl_stat_type;

endpackage

// ===== hdl/fale_req_if.sv =====
// Request channel of the frame allocator.
interface fale_req_if;
   logic                          valid;
   logic                          ready;
   logic [fale_pkg::CMD_W-1:0]    cmd;
   logic [fale_pkg::PID_W-1:0]    process_id;
   logic [fale_pkg::KB_W-1:0]     mem_kb;
   logic [fale_pkg::TIME_W-1:0]   use_time;

   modport source (output valid, cmd, process_id, mem_kb, use_time, input ready);
   modport sink (input valid, cmd, process_id, mem_kb, use_time, output ready);
endinterface

// ===== hdl/fale_rsp_if.sv =====
// Response channel of the frame allocator.
interface fale_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [fale_pkg::STATUS_W-1:0]   status;
   logic [fale_pkg::MAP_W-1:0]      granted_map;
   logic [fale_pkg::MAP_W-1:0]      evicted_map;
   logic [fale_pkg::COUNT_W-1:0]    free_count;

   modport source (output valid, status, granted_map, evicted_map, free_count, input ready);
   modport sink (input valid, status, granted_map, evicted_map, free_count, output ready);
endinterface

// ===== hdl/fale_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fale_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

// ===== hdl/fale_ctrl.sv =====
// Sequencer of the frame allocator: divide, victim search, evict and grant rounds.
module fale_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  fale_pkg::ctrl_stat_type stat,
   output fale_pkg::ctrl_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_DIV      = 4'd2;
   localparam logic [3:0] S_LOOP     = 4'd3;
   localparam logic [3:0] S_VSCAN    = 4'd4;
   localparam logic [3:0] S_VCHK     = 4'd5;
   localparam logic [3:0] S_EVICT    = 4'd6;
   localparam logic [3:0] S_FREE     = 4'd7;
   localparam logic [3:0] S_GRANT    = 4'd8;
   localparam logic [3:0] S_FIN      = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (stat.cmd)
               fale_pkg::CMD_TOUCH: begin
                  cmd.touch_we = 1'b1;
                  state_in     = S_FIN;
               end
               fale_pkg::CMD_FREE: begin
                  cmd.scan_start = 1'b1;
                  cmd.scan_kind  = fale_pkg::SCAN_EVICT;
                  cmd.use_self   = 1'b1;
                  cmd.limit_all  = 1'b1;
                  state_in       = S_FREE;
               end
               fale_pkg::CMD_ALLOC: begin
                  cmd.div_start = 1'b1;
                  state_in      = S_DIV;
               end
               default: begin
                  state_in = S_FIN;
               end
            endcase
         end
         S_DIV: begin
            if (stat.div_done) begin
               state_in = S_LOOP;
            end
         end
         S_LOOP: begin
            cmd.scan_start = 1'b1;
            if ((stat.mode == fale_pkg::MODE_WHOLE) ? stat.free_lt_pages : stat.part_more) begin
               cmd.scan_kind = fale_pkg::SCAN_VICTIM;
               state_in      = S_VSCAN;
            end else begin
               cmd.scan_kind = fale_pkg::SCAN_GRANT;
               cmd.use_self  = 1'b1;
               state_in      = S_GRANT;
            end
         end
         S_VSCAN: begin
            if (stat.scan_done) begin
               state_in = S_VCHK;
            end
         end
         S_VCHK: begin
            cmd.scan_start = 1'b1;
            if (!stat.found || (stat.mode == fale_pkg::MODE_PARTIAL && !stat.want_pos)) begin
               cmd.scan_kind = fale_pkg::SCAN_GRANT;
               cmd.use_self  = 1'b1;
               state_in      = S_GRANT;
            end else begin
               cmd.scan_kind = fale_pkg::SCAN_EVICT;
               cmd.limit_all = (stat.mode == fale_pkg::MODE_WHOLE);
               state_in      = S_EVICT;
            end
         end
         S_EVICT: begin
            if (stat.scan_done) begin
               if (stat.mode == fale_pkg::MODE_PARTIAL && stat.evict_none) begin
                  cmd.scan_start = 1'b1;
                  cmd.scan_kind  = fale_pkg::SCAN_GRANT;
                  cmd.use_self   = 1'b1;
                  state_in       = S_GRANT;
               end else begin
                  state_in = S_LOOP;
               end
            end
         end
         S_FREE, S_GRANT: begin
            if (stat.scan_done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/fale_dpath.sv =====
// Datapath of the frame allocator: frame table, process tables, divider and scan unit.
`include "frame_allocator_lru_evict_core_assert.svh"
module fale_dpath #(
   parameter int FRAMES    = 64,
   parameter int PAGE_KB   = 4,
   parameter int PROCESSES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [fale_pkg::CMD_W-1:0]          req_cmd,
   input  logic [fale_pkg::PID_W-1:0]          req_process_id,
   input  logic [fale_pkg::KB_W-1:0]           req_mem_kb,
   input  logic [fale_pkg::TIME_W-1:0]         req_use_time,
   input  logic                                csr_we,
   input  logic [fale_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fale_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  fale_pkg::ctrl_cmd_type              cmd_i,
   output fale_pkg::ctrl_stat_type             stat,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [fale_pkg::STATUS_W-1:0]       rsp_status,
   output logic [fale_pkg::MAP_W-1:0]          rsp_granted_map,
   output logic [fale_pkg::MAP_W-1:0]          rsp_evicted_map,
   output logic [fale_pkg::COUNT_W-1:0]        rsp_free_count
);

   localparam int PROC_N    = (PROCESSES < 16) ? PROCESSES : 16;
   localparam int PIDX_W    = $clog2(PROC_N);
   localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int DVD_W     = fale_pkg::KB_W + 1;
   localparam int CW        = fale_pkg::COUNT_W;
   localparam int KW        = fale_pkg::KB_W;
   localparam int RCP_L     = (PAGE_KB > 1) ? $clog2(PAGE_KB) : 0;
   localparam int RCP_S     = DVD_W + RCP_L;
   localparam int RCP_W     = DVD_W + 1;
   localparam int PRD_W     = DVD_W + RCP_W;
   localparam logic [DVD_W-1:0] PAGE_BIAS = DVD_W'(PAGE_KB - 1);
   localparam logic [RCP_W-1:0] RCP_M     = RCP_W'((2 ** RCP_S + PAGE_KB - 1) / PAGE_KB);
   localparam logic [CW-1:0]    FRAMES_CNT = CW'(FRAMES);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(FRAMES - 1);

   function automatic logic [PIDX_W-1:0] reduce_pid(input logic [fale_pkg::PID_W-1:0] raw);
      logic [fale_pkg::PID_W-1:0] m;
      m = raw;
      for (int i = 0; i < 8; i++) begin
         if (32'(m) >= PROCESSES) begin
            m = fale_pkg::PID_W'(32'(m) - PROCESSES);
         end
      end
      return PIDX_W'(m);
   endfunction

   logic [fale_pkg::CMD_W-1:0]    cmd_ff;
   logic [PIDX_W-1:0]             pid_ff;
   logic [fale_pkg::TIME_W-1:0]   time_ff;
   logic                          mode_ff;
   logic [CW-1:0]                 minres_ff;
   logic [DVD_W-1:0]              dvd_ff;
   logic                          div_done_ff;
   logic [FRAMES-1:0]             valid_ff;
   logic [CW-1:0]                 free_ff;
   logic [CW-1:0]                 held_ff [PROC_N];
   logic [fale_pkg::TIME_W-1:0]   last_ff [PROC_N];
   logic                          scan_busy_ff;
   fale_pkg::scan_kind_type       kind_ff;
   logic [IDX_W-1:0]              addr_ff;
   logic                          rd_valid_ff;
   logic [IDX_W-1:0]              rd_idx_ff;
   logic                          v_rd_ff;
   logic                          done_ff;
   logic [CW-1:0]                 cnt_ff;
   logic [CW-1:0]                 limit_ff;
   logic [PIDX_W-1:0]             target_ff;
   logic                          clear_ff;
   logic                          found_ff;
   logic [PIDX_W-1:0]             best_ff;
   logic [fale_pkg::TIME_W-1:0]   best_time_ff;
   logic [FRAMES-1:0]             gmap_ff;
   logic [FRAMES-1:0]             emap_ff;
   logic [fale_pkg::STATUS_W-1:0] status_ff;
   logic                          rsp_valid_ff;

   logic [KW-1:0]                 pages;
   logic [CW-1:0]                 held_self;
   logic [KW-1:0]                 need;
   logic [CW-1:0]                 minreq;
   logic signed [8:0]             want;
   logic [KW-1:0]                 grant_want;
   logic [CW-1:0]                 limit_in;
   logic [PRD_W-1:0]              product;
   logic [PRD_W-1:0]              quotient;
   logic [PIDX_W-1:0]             own;
   logic                          v_rd;
   logic                          hit_evict;
   logic                          hit_grant;
   logic                          better;
   logic [CW-1:0]                 held_cur;
   logic [CW-1:0]                 held_sub;

   fale_ram #(.WIDTH(PIDX_W), .DEPTH(FRAMES)) u_owner (
      .clock (clock),
      .we    (hit_grant),
      .waddr (rd_idx_ff),
      .wdata (target_ff),
      .raddr (addr_ff),
      .rdata (own)
   );

   always_comb begin
      pages      = dvd_ff[KW-1:0];
      held_self  = held_ff[pid_ff];
      need       = (pages > KW'(held_self)) ? (pages - KW'(held_self)) : '0;
      minreq     = (pages < KW'(minres_ff)) ? pages[CW-1:0] : minres_ff;
      want       = $signed({2'b00, minreq}) - $signed({2'b00, held_self})
                   - $signed({2'b00, free_ff});
      grant_want = (mode_ff == fale_pkg::MODE_PARTIAL) ? need : pages;
      unique case (cmd_i.scan_kind)
         fale_pkg::SCAN_GRANT: begin
            limit_in = (grant_want > KW'({CW{1'b1}})) ? {CW{1'b1}} : grant_want[CW-1:0];
         end
         fale_pkg::SCAN_EVICT: begin
            limit_in = cmd_i.limit_all ? FRAMES_CNT : want[CW-1:0];
         end
         default: begin
            limit_in = '0;
         end
      endcase
      product   = PRD_W'(dvd_ff) * PRD_W'(RCP_M);
      quotient  = product >> RCP_S;
      v_rd      = v_rd_ff;
      hit_evict = rd_valid_ff && (kind_ff == fale_pkg::SCAN_EVICT) && v_rd
                  && (own == target_ff) && (cnt_ff < limit_ff);
      hit_grant = rd_valid_ff && (kind_ff == fale_pkg::SCAN_GRANT) && !v_rd
                  && (cnt_ff < limit_ff);
      better    = rd_valid_ff && (kind_ff == fale_pkg::SCAN_VICTIM) && v_rd
                  && (own != pid_ff) && (!found_ff || (last_ff[own] < best_time_ff));
      held_cur  = held_ff[target_ff];
      held_sub  = (held_cur > cnt_ff) ? (held_cur - cnt_ff) : '0;

      stat.cmd           = cmd_ff;
      stat.mode          = mode_ff;
      stat.div_done      = div_done_ff;
      stat.scan_done     = done_ff;
      stat.free_lt_pages = (KW'(free_ff) < pages);
      stat.part_more     = (KW'(free_ff) < need) && (free_ff < minres_ff);
      stat.found         = found_ff;
      stat.want_pos      = !want[8] && (want != '0);
      stat.evict_none    = (cnt_ff == '0);
      stat.rsp_free      = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff       <= fale_pkg::CMD_TOUCH;
         mode_ff      <= fale_pkg::MODE_WHOLE;
         minres_ff    <= fale_pkg::MIN_RESIDENT_RST;
         div_done_ff  <= 1'b0;
         valid_ff     <= '0;
         free_ff      <= FRAMES_CNT;
         scan_busy_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < PROC_N; i++) begin
            held_ff[i] <= '0;
            last_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               fale_pkg::CSR_ALLOC_MODE:   mode_ff   <= csr_wdata[0];
               fale_pkg::CSR_MIN_RESIDENT: minres_ff <= csr_wdata;
               default:                    minres_ff <= minres_ff;
            endcase
         end
         if (cmd_i.load_req) begin
            cmd_ff <= req_cmd;
         end
         if (cmd_i.touch_we) begin
            last_ff[pid_ff] <= time_ff;
         end

         div_done_ff <= cmd_i.div_start;

         if (hit_evict) begin
            valid_ff[rd_idx_ff] <= 1'b0;
            free_ff             <= free_ff + 1'b1;
         end else if (hit_grant) begin
            valid_ff[rd_idx_ff] <= 1'b1;
            free_ff             <= free_ff - 1'b1;
         end

         if (cmd_i.scan_start) begin
            scan_busy_ff <= 1'b1;
         end else if (scan_busy_ff && addr_ff == LAST_IDX) begin
            scan_busy_ff <= 1'b0;
         end
         rd_valid_ff <= scan_busy_ff;
         done_ff     <= rd_valid_ff && (rd_idx_ff == LAST_IDX);

         if (done_ff) begin
            unique case (kind_ff)
               fale_pkg::SCAN_EVICT: held_ff[target_ff] <= clear_ff ? '0 : held_sub;
               fale_pkg::SCAN_GRANT: held_ff[target_ff] <= held_cur + cnt_ff;
               default:              held_ff[target_ff] <= held_cur;
            endcase
         end

         if (cmd_i.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.load_req) begin
         pid_ff    <= reduce_pid(req_process_id);
         time_ff   <= req_use_time;
         dvd_ff    <= {1'b0, req_mem_kb} + PAGE_BIAS;
         gmap_ff   <= '0;
         emap_ff   <= '0;
         status_ff <= fale_pkg::STATUS_OK;
      end else if (cmd_i.div_start) begin
         dvd_ff <= quotient[DVD_W-1:0];
      end

      if (cmd_i.scan_start) begin
         kind_ff   <= cmd_i.scan_kind;
         addr_ff   <= '0;
         cnt_ff    <= '0;
         limit_ff  <= limit_in;
         target_ff <= cmd_i.use_self ? pid_ff : best_ff;
         clear_ff  <= cmd_i.use_self;
         found_ff  <= 1'b0;
      end else begin
         if (scan_busy_ff && addr_ff != LAST_IDX) begin
            addr_ff <= addr_ff + 1'b1;
         end
         if (hit_evict || hit_grant) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (better) begin
            found_ff     <= 1'b1;
            best_ff      <= own;
            best_time_ff <= last_ff[own];
         end
      end
      rd_idx_ff <= addr_ff;
      v_rd_ff   <= valid_ff[addr_ff];

      if (hit_evict) begin
         emap_ff[rd_idx_ff] <= 1'b1;
      end
      if (hit_grant) begin
         gmap_ff[rd_idx_ff] <= 1'b1;
      end

      if (done_ff && kind_ff == fale_pkg::SCAN_EVICT && clear_ff) begin
         status_ff <= (cnt_ff == '0) ? fale_pkg::STATUS_NONE : fale_pkg::STATUS_OK;
      end else if (done_ff && kind_ff == fale_pkg::SCAN_GRANT) begin
         if (mode_ff == fale_pkg::MODE_WHOLE) begin
            status_ff <= (KW'(cnt_ff) == pages) ? fale_pkg::STATUS_OK : fale_pkg::STATUS_SHORT;
         end else begin
            status_ff <= ({1'b0, held_cur} + {1'b0, cnt_ff} >= {1'b0, minreq})
                         ? fale_pkg::STATUS_OK : fale_pkg::STATUS_SHORT;
         end
      end

      if (cmd_i.rsp_load) begin
         rsp_status      <= status_ff;
         rsp_granted_map <= fale_pkg::MAP_W'(gmap_ff);
         rsp_evicted_map <= fale_pkg::MAP_W'(emap_ff);
         rsp_free_count  <= free_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `FALE_ASSERT_HOLDS(a_free_count, 32'(free_ff) + $countones(valid_ff) == FRAMES, "free count out of step with frame table")
   `FALE_ASSERT_IMPLIES(a_rsp_slot, cmd_i.rsp_load, !rsp_valid_ff || rsp_ready, "response overwritten")
   `FALE_ASSERT_IMPLIES(a_scan_idle, cmd_i.scan_start, !scan_busy_ff && !rd_valid_ff, "scan restarted while running")

endmodule

// ===== hdl/frame_allocator_lru_evict_core.sv =====
// Frame allocator with least-recently-used process eviction: top level.
//
// Requests enter on req_ch (valid/ready): cmd 0 allocates ceil(mem_kb/PAGE_KB)
// pages for process_id, cmd 1 frees all frames of the process, cmd 2 records
// use_time as the process's last use. Each request yields one item on rsp_ch
// with status, granted and evicted frame maps and the free frame count.
// alloc_mode and min_resident are written through csr_we/csr_index/csr_wdata.
// One request is worked at a time. Touch and the unused command go straight
// to the response; free runs one evict scan over the process's own frames;
// allocate computes the page count, then runs eviction rounds (one victim
// scan, one evict scan) and finally a grant scan. Every scan reads the frame
// owner memory one frame a cycle.
// Reset empties the frame table, clears frame counts and last-use times and
// loads alloc_mode 0, min_resident 4. A finished response waits in an output
// register while rsp_ch.ready is low; the next request is accepted meanwhile
// and completes once that register is taken.
module frame_allocator_lru_evict_core #(
   parameter int FRAMES    = 64,
   parameter int PAGE_KB   = 4,
   parameter int PROCESSES = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   fale_req_if.sink                         req_ch,
   fale_rsp_if.source                       rsp_ch,
   input  logic                             csr_we,
   input  logic [fale_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fale_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   fale_pkg::ctrl_cmd_type  ctl_cmd;
   fale_pkg::ctrl_stat_type ctl_stat;

   fale_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (ctl_stat),
      .cmd       (ctl_cmd)
   );

   fale_dpath #(
      .FRAMES    (FRAMES),
      .PAGE_KB   (PAGE_KB),
      .PROCESSES (PROCESSES)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_cmd         (req_ch.cmd),
      .req_process_id  (req_ch.process_id),
      .req_mem_kb      (req_ch.mem_kb),
      .req_use_time    (req_ch.use_time),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .cmd_i           (ctl_cmd),
      .stat            (ctl_stat),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_status      (rsp_ch.status),
      .rsp_granted_map (rsp_ch.granted_map),
      .rsp_evicted_map (rsp_ch.evicted_map),
      .rsp_free_count  (rsp_ch.free_count)
   );

endmodule
